@@ src/gdsa_pkg.sv @@
`default_nettype none
package gdsa_pkg;

   localparam int ID_BITS = 20;
   localparam logic [31:0] SCALE_RESET = 32'h0100_0000;

   localparam logic OPC_TARGET = 1'b0;
   localparam logic OPC_SOURCE = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        mass;
      logic [ID_BITS-1:0] particle_id;
      logic               last;
   } gdsa_req_type;

   typedef struct packed {
      logic signed [63:0] acc_x;
      logic signed [63:0] acc_y;
      logic signed [63:0] acc_z;
      logic signed [63:0] potential;
   } gdsa_rsp_type;

   typedef struct packed {
      logic        done;
      logic [4:0]  k;
      logic [32:0] g;
   } gdsa_root_res_type;

   typedef enum logic [2:0] {
      RS_IDLE, RS_NORM, RS_SQRT, RS_DIV, RS_DONE
   } gdsa_rs_state_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_MUL, ST_RSTART, ST_ROOT, ST_POT, ST_ACC, ST_FIN
   } gdsa_state_type;

   typedef enum logic [3:0] {
      OP_SQ, OP_F, OP_PLO, OP_PHI, OP_U, OP_V, OP_W, OP_A0, OP_A1, OP_A2, OP_A3
   } gdsa_op_type;

endpackage
`default_nettype wire

@@ src/gdsa_root.sv @@
`default_nettype none
// Normalize r2 by powers of four, integer square root, then g = 2^63 / q.
module gdsa_root (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [63:0]                r2,
   output gdsa_pkg::gdsa_root_res_type     res
);

   gdsa_pkg::gdsa_rs_state_type state_ff, state_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] root_ff, root_in;
   logic [4:0]  k_ff, k_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] g_ff, g_in;

   logic [63:0] bit_w;
   logic [63:0] trial;
   logic [33:0] r_sh;
   logic [33:0] qv;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      root_in  = root_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      g_in     = g_ff;
      bit_w    = 64'd1 << (6'd62 - {cnt_ff[4:0], 1'b0});
      trial    = root_ff + bit_w;
      r_sh     = {rem_ff, 1'b0};
      qv       = {2'b00, root_ff[31:0]};
      unique case (state_ff)
         gdsa_pkg::RS_IDLE: begin
            if (start) begin
               x_in     = r2;
               k_in     = 5'd0;
               state_in = gdsa_pkg::RS_NORM;
            end
         end
         gdsa_pkg::RS_NORM: begin
            if (x_ff[63:62] == 2'b00) begin
               x_in = x_ff << 2;
               k_in = k_ff + 5'd1;
            end else begin
               root_in  = 64'd0;
               cnt_in   = 6'd0;
               state_in = gdsa_pkg::RS_SQRT;
            end
         end
         gdsa_pkg::RS_SQRT: begin
            if (x_ff >= trial) begin
               x_in    = x_ff - trial;
               root_in = (root_ff >> 1) + bit_w;
            end else begin
               root_in = root_ff >> 1;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[4:0] == 5'd31) begin
               // top bits of 2^63 already shifted in
               rem_in   = 33'h0_4000_0000;
               g_in     = 33'd0;
               cnt_in   = 6'd32;
               state_in = gdsa_pkg::RS_DIV;
            end
         end
         gdsa_pkg::RS_DIV: begin
            if (r_sh >= qv) begin
               rem_in = 33'(r_sh - qv);
               g_in   = {g_ff[31:0], 1'b1};
            end else begin
               rem_in = r_sh[32:0];
               g_in   = {g_ff[31:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = gdsa_pkg::RS_DONE;
         end
         gdsa_pkg::RS_DONE: begin
            state_in = gdsa_pkg::RS_IDLE;
         end
         default: state_in = gdsa_pkg::RS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= gdsa_pkg::RS_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      root_ff <= root_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      g_ff    <= g_in;
   end

   assign res.done = (state_ff == gdsa_pkg::RS_DONE);
   assign res.k    = k_ff;
   assign res.g    = g_ff;

endmodule
`default_nettype wire

@@ src/gravity_direct_sum_accumulator_top.sv @@
`default_nettype none
// Direct-sum gravity on one target particle.
// req channel (valid/ready): opcode 0 loads the target position and id and
// clears the accumulators; opcode 1 adds one source. A beat with last set
// on a source returns one rsp beat with the three acceleration sums and the
// potential, all Q24.40 and saturated. csr_we writes gravity_scale (Q8.24).
// A target load completes when accepted; a self source goes straight to
// the final step, and a zero-separation source passes the prepare step
// first. Any other source runs one item at a time through the shared
// 33x33 multiplier (27 products, each a multiply and an accumulate phase)
// and the root unit (up to 32 normalize, 32 square-root, 33 divide steps).
// The result sits in an output register; the next item is taken while it
// waits. If a second result is ready before the first beat is taken, the
// block holds in its final step until rsp_ready.
// Reset (synchronous) clears target, sums and rsp_valid and loads
// gravity_scale with 1.0.
module gravity_direct_sum_accumulator_top (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire gdsa_pkg::gdsa_req_type req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      gdsa_pkg::gdsa_rsp_type rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [31:0]           csr_wdata
);

   gdsa_pkg::gdsa_state_type state_ff, state_in;
   gdsa_pkg::gdsa_op_type    op_ff, op_in;
   logic                     phase_ff, phase_in;
   logic [1:0]               axis_ff, axis_in;

   logic [31:0]              scale_ff, scale_in;
   logic signed [31:0]       tgt_ff [3];
   logic signed [31:0]       tgt_in [3];
   logic [gdsa_pkg::ID_BITS-1:0] tid_ff, tid_in;
   logic signed [63:0]       sum_ff [3];
   logic signed [63:0]       sum_in [3];
   logic signed [63:0]       pot_ff, pot_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   gdsa_pkg::gdsa_req_type   item_ff, item_in;
   gdsa_pkg::gdsa_rsp_type   rsp_ff, rsp_in;
   logic [30:0]              n_ff [3];
   logic [30:0]              n_in [3];
   logic [2:0]               neg_ff, neg_in;
   logic [1:0]               e_ff, e_in;
   logic [4:0]               k_ff, k_in;
   logic [32:0]              g_ff, g_in;
   logic [63:0]              r2_ff, r2_in;
   logic [63:0]              f_ff, f_in;
   logic [31:0]              u_ff, u_in;
   logic [31:0]              v_ff, v_in;
   logic [63:0]              w_ff, w_in;
   logic [127:0]             acc_ff, acc_in;
   logic [65:0]              prod_ff, prod_in;

   logic [32:0]              mul_a, mul_b;
   logic signed [32:0]       dr [3];
   logic [32:0]              mag [3];
   logic [32:0]              mx;
   logic [1:0]               e_w;
   logic [63:0]              nk;
   logic [6:0]               s_pot, s_acc;
   logic [63:0]              term;
   logic signed [63:0]       sterm;
   logic                     root_start;
   gdsa_pkg::gdsa_root_res_type root_res;
   logic                     req_fire;

   function automatic logic [63:0] shr_cap(input logic [127:0] v, input logic [6:0] s);
      logic [127:0] sh;
      sh = v >> s;
      if (sh[127:63] != '0) return 64'h7FFF_FFFF_FFFF_FFFF;
      return sh[63:0];
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic [64:0] t;
      t = {a[63], a} + {b[63], b};
      if (t[64] != t[63]) return t[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      return t[63:0];
   endfunction

   gdsa_root u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .r2    (r2_ff),
      .res   (root_res)
   );

   assign req_ready  = (state_ff == gdsa_pkg::ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign root_start = (state_ff == gdsa_pkg::ST_RSTART);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // separation, magnitudes and range scale
   always_comb begin
      dr[0] = {item_ff.pos_x[31], item_ff.pos_x} - {tgt_ff[0][31], tgt_ff[0]};
      dr[1] = {item_ff.pos_y[31], item_ff.pos_y} - {tgt_ff[1][31], tgt_ff[1]};
      dr[2] = {item_ff.pos_z[31], item_ff.pos_z} - {tgt_ff[2][31], tgt_ff[2]};
      for (int j = 0; j < 3; j++) begin
         mag[j] = dr[j][32] ? (~dr[j] + 33'd1) : dr[j];
      end
      mx = mag[0];
      if (mag[1] > mx) mx = mag[1];
      if (mag[2] > mx) mx = mag[2];
      if (mx[32])      e_w = 2'd2;
      else if (mx[31]) e_w = 2'd1;
      else             e_w = 2'd0;
   end

   // shared multiplier operand select
   always_comb begin
      nk = {33'd0, n_ff[axis_ff]} << k_ff;
      unique case (op_ff)
         gdsa_pkg::OP_SQ:  begin mul_a = {2'b0, n_ff[axis_ff]}; mul_b = {2'b0, n_ff[axis_ff]}; end
         gdsa_pkg::OP_F:   begin mul_a = {1'b0, scale_ff};      mul_b = {1'b0, item_ff.mass}; end
         gdsa_pkg::OP_PLO: begin mul_a = {1'b0, f_ff[31:0]};    mul_b = g_ff; end
         gdsa_pkg::OP_PHI: begin mul_a = {1'b0, f_ff[63:32]};   mul_b = g_ff; end
         gdsa_pkg::OP_U:   begin mul_a = {1'b0, nk[31:0]};      mul_b = g_ff; end
         gdsa_pkg::OP_V:   begin mul_a = {1'b0, u_ff};          mul_b = g_ff; end
         gdsa_pkg::OP_W:   begin mul_a = {1'b0, v_ff};          mul_b = g_ff; end
         gdsa_pkg::OP_A0:  begin mul_a = {1'b0, f_ff[31:0]};    mul_b = {1'b0, w_ff[31:0]}; end
         gdsa_pkg::OP_A1:  begin mul_a = {1'b0, f_ff[31:0]};    mul_b = {1'b0, w_ff[63:32]}; end
         gdsa_pkg::OP_A2:  begin mul_a = {1'b0, f_ff[63:32]};   mul_b = {1'b0, w_ff[31:0]}; end
         gdsa_pkg::OP_A3:  begin mul_a = {1'b0, f_ff[63:32]};   mul_b = {1'b0, w_ff[63:32]}; end
         default:          begin mul_a = '0;                    mul_b = '0; end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      phase_in     = phase_ff;
      axis_in      = axis_ff;
      scale_in     = csr_we ? csr_wdata : scale_ff;
      tgt_in       = tgt_ff;
      tid_in       = tid_ff;
      sum_in       = sum_ff;
      pot_in       = pot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      n_in         = n_ff;
      neg_in       = neg_ff;
      e_in         = e_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      r2_in        = r2_ff;
      f_in         = f_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      s_pot        = 7'd55 + {5'd0, e_ff} - {2'd0, k_ff};
      s_acc        = 7'd93 + {4'd0, e_ff, 1'b0} - {1'b0, k_ff, 1'b0};
      term         = shr_cap(acc_ff, (state_ff == gdsa_pkg::ST_POT) ? s_pot : s_acc);
      sterm        = neg_ff[axis_ff] ? (64'sd0 - $signed(term)) : $signed(term);

      unique case (state_ff)
         gdsa_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.opcode == gdsa_pkg::OPC_TARGET) begin
                  tgt_in[0] = req_data.pos_x;
                  tgt_in[1] = req_data.pos_y;
                  tgt_in[2] = req_data.pos_z;
                  tid_in    = req_data.particle_id;
                  sum_in[0] = '0;
                  sum_in[1] = '0;
                  sum_in[2] = '0;
                  pot_in    = '0;
               end else begin
                  item_in  = req_data;
                  state_in = (req_data.particle_id == tid_ff) ? gdsa_pkg::ST_FIN
                                                              : gdsa_pkg::ST_PREP;
               end
            end
         end
         gdsa_pkg::ST_PREP: begin
            if (mx == 33'd0) begin
               state_in = gdsa_pkg::ST_FIN;
            end else begin
               for (int j = 0; j < 3; j++) begin
                  n_in[j]   = 31'(mag[j] >> e_w);
                  neg_in[j] = dr[j][32];
               end
               e_in     = e_w;
               r2_in    = '0;
               axis_in  = 2'd0;
               op_in    = gdsa_pkg::OP_SQ;
               phase_in = 1'b0;
               state_in = gdsa_pkg::ST_MUL;
            end
         end
         gdsa_pkg::ST_MUL: begin
            phase_in = !phase_ff;
            if (!phase_ff) begin
               prod_in = {33'd0, mul_a} * {33'd0, mul_b};
            end else begin
               unique case (op_ff)
                  gdsa_pkg::OP_SQ: begin
                     r2_in = r2_ff + prod_ff[63:0];
                     if (axis_ff == 2'd2) begin
                        axis_in  = 2'd0;
                        state_in = gdsa_pkg::ST_RSTART;
                     end else begin
                        axis_in = axis_ff + 2'd1;
                     end
                  end
                  gdsa_pkg::OP_F: begin
                     f_in  = prod_ff[63:0];
                     op_in = gdsa_pkg::OP_PLO;
                  end
                  gdsa_pkg::OP_PLO: begin
                     acc_in = {62'd0, prod_ff};
                     op_in  = gdsa_pkg::OP_PHI;
                  end
                  gdsa_pkg::OP_PHI: begin
                     acc_in   = acc_ff + ({62'd0, prod_ff} << 32);
                     state_in = gdsa_pkg::ST_POT;
                  end
                  gdsa_pkg::OP_U: begin
                     u_in  = prod_ff[63:32];
                     op_in = gdsa_pkg::OP_V;
                  end
                  gdsa_pkg::OP_V: begin
                     v_in  = prod_ff[63:32];
                     op_in = gdsa_pkg::OP_W;
                  end
                  gdsa_pkg::OP_W: begin
                     w_in  = prod_ff[63:0];
                     op_in = gdsa_pkg::OP_A0;
                  end
                  gdsa_pkg::OP_A0: begin
                     acc_in = {62'd0, prod_ff};
                     op_in  = gdsa_pkg::OP_A1;
                  end
                  gdsa_pkg::OP_A1: begin
                     acc_in = acc_ff + ({62'd0, prod_ff} << 32);
                     op_in  = gdsa_pkg::OP_A2;
                  end
                  gdsa_pkg::OP_A2: begin
                     acc_in = acc_ff + ({62'd0, prod_ff} << 32);
                     op_in  = gdsa_pkg::OP_A3;
                  end
                  gdsa_pkg::OP_A3: begin
                     acc_in   = acc_ff + ({62'd0, prod_ff} << 64);
                     state_in = gdsa_pkg::ST_ACC;
                  end
                  default: state_in = gdsa_pkg::ST_IDLE;
               endcase
            end
         end
         gdsa_pkg::ST_RSTART: begin
            state_in = gdsa_pkg::ST_ROOT;
         end
         gdsa_pkg::ST_ROOT: begin
            if (root_res.done) begin
               g_in     = root_res.g;
               k_in     = root_res.k;
               op_in    = gdsa_pkg::OP_F;
               phase_in = 1'b0;
               state_in = gdsa_pkg::ST_MUL;
            end
         end
         gdsa_pkg::ST_POT: begin
            pot_in   = sat_add(pot_ff, 64'sd0 - $signed(term));
            axis_in  = 2'd0;
            op_in    = gdsa_pkg::OP_U;
            phase_in = 1'b0;
            state_in = gdsa_pkg::ST_MUL;
         end
         gdsa_pkg::ST_ACC: begin
            sum_in[axis_ff] = sat_add(sum_ff[axis_ff], sterm);
            phase_in = 1'b0;
            if (axis_ff == 2'd2) begin
               state_in = gdsa_pkg::ST_FIN;
            end else begin
               axis_in  = axis_ff + 2'd1;
               op_in    = gdsa_pkg::OP_U;
               state_in = gdsa_pkg::ST_MUL;
            end
         end
         gdsa_pkg::ST_FIN: begin
            if (!item_ff.last) begin
               state_in = gdsa_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.acc_x     = sum_ff[0];
               rsp_in.acc_y     = sum_ff[1];
               rsp_in.acc_z     = sum_ff[2];
               rsp_in.potential = pot_ff;
               rsp_valid_in     = 1'b1;
               state_in         = gdsa_pkg::ST_IDLE;
            end
         end
         default: state_in = gdsa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdsa_pkg::ST_IDLE;
         op_ff        <= gdsa_pkg::OP_SQ;
         phase_ff     <= 1'b0;
         axis_ff      <= 2'd0;
         scale_ff     <= gdsa_pkg::SCALE_RESET;
         tgt_ff[0]    <= '0;
         tgt_ff[1]    <= '0;
         tgt_ff[2]    <= '0;
         tid_ff       <= '0;
         sum_ff[0]    <= '0;
         sum_ff[1]    <= '0;
         sum_ff[2]    <= '0;
         pot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         axis_ff      <= axis_in;
         scale_ff     <= scale_in;
         tgt_ff       <= tgt_in;
         tid_ff       <= tid_in;
         sum_ff       <= sum_in;
         pot_ff       <= pot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      n_ff    <= n_in;
      neg_ff  <= neg_in;
      e_ff    <= e_in;
      k_ff    <= k_in;
      g_ff    <= g_in;
      r2_ff   <= r2_in;
      f_ff    <= f_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      w_ff    <= w_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

@@ verif/gravity_direct_sum_accumulator_top_tb.sv @@
`default_nettype none
module gravity_direct_sum_accumulator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 3_000_000;
   localparam int SETTLE_CYCLES = 400;

   typedef logic [gdsa_pkg::ID_BITS-1:0] id_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   gdsa_pkg::gdsa_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   gdsa_pkg::gdsa_rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   gravity_direct_sum_accumulator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predictor state
   bit [31:0] scale_m = gdsa_pkg::SCALE_RESET;
   longint tgt_x = 0, tgt_y = 0, tgt_z = 0;
   bit [gdsa_pkg::ID_BITS-1:0] tgt_id = '0;
   longint sum_a[3] = '{0, 0, 0};
   longint sum_pot = 0;

   gdsa_pkg::gdsa_req_type pending_items[$];
   gdsa_pkg::gdsa_rsp_type expected_sums[$];
   int errors = 0;
   int n_targets = 0, n_sources = 0, n_skipped = 0, n_results = 0, n_scales = 0;
   longint cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic bit [63:0] shr_cap(bit [127:0] p, int s);
      bit [127:0] r;
      r = p >> s;
      if (r[127:63] != 0) return 64'h7fff_ffff_ffff_ffff;
      return r[63:0];
   endfunction

   function automatic longint sat_sum(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(signed'(a)) + 65'(signed'(b));
      if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return longint'(s[63:0]);
   endfunction

   // one source's contribution to the running sums
   function automatic void add_source(gdsa_pkg::gdsa_req_type it);
      longint dr[3];
      bit [63:0] mag[3], n[3];
      bit [63:0] mx, r2, x, res, probe, f, q, g, u, w, t;
      int e, k;
      dr[0] = longint'(it.pos_x) - tgt_x;
      dr[1] = longint'(it.pos_y) - tgt_y;
      dr[2] = longint'(it.pos_z) - tgt_z;
      mx = 0;
      for (int j = 0; j < 3; j++) begin
         mag[j] = dr[j] < 0 ? -dr[j] : dr[j];
         if (mag[j] > mx) mx = mag[j];
      end
      if (mx == 0) begin
         n_skipped++;
         return;
      end
      e = 0;
      while ((mx >> e) >= 64'h8000_0000) e++;
      r2 = 0;
      for (int j = 0; j < 3; j++) begin
         n[j] = mag[j] >> e;
         r2 += n[j] * n[j];
      end
      k = 0;
      while ((r2 >> 62) == 0) begin
         r2 <<= 2;
         k++;
      end
      x = r2;
      res = 0;
      probe = 64'h1 << 62;
      while (probe > x) probe >>= 2;
      while (probe != 0) begin
         if (x >= res + probe) begin
            x -= res + probe;
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      q = res;
      g = (64'h1 << 63) / q;
      f = 64'(scale_m) * 64'(it.mass);
      sum_pot = sat_sum(sum_pot, -longint'(shr_cap(128'(f) * 128'(g), 55 + e - k)));
      for (int j = 0; j < 3; j++) begin
         u = ((n[j] << k) * g) >> 32;       // 64-bit wrap is intended
         w = ((u * g) >> 32) * g;
         t = shr_cap(128'(f) * 128'(w), 93 + 2 * e - 2 * k);
         sum_a[j] = sat_sum(sum_a[j], dr[j] < 0 ? -longint'(t) : longint'(t));
      end
   endfunction

   function automatic void predict_beat(gdsa_pkg::gdsa_req_type it);
      gdsa_pkg::gdsa_rsp_type r;
      if (it.opcode == gdsa_pkg::OPC_TARGET) begin
         tgt_x = longint'(it.pos_x);
         tgt_y = longint'(it.pos_y);
         tgt_z = longint'(it.pos_z);
         tgt_id = it.particle_id;
         sum_a = '{0, 0, 0};
         sum_pot = 0;
         n_targets++;
         return;
      end
      n_sources++;
      if (it.particle_id != tgt_id) add_source(it);
      else n_skipped++;
      if (it.last) begin
         r.acc_x = sum_a[0];
         r.acc_y = sum_a[1];
         r.acc_z = sum_a[2];
         r.potential = sum_pot;
         expected_sums.push_back(r);
      end
   endfunction

   // driver: bursts with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_beat(req_data);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch expected %h actual %h", $realtime, name, want, got);
      end
   endtask

   // monitor and result-side stall pattern
   int stall_mode = 0, mode_left = 0;
   always @(posedge clock) begin
      gdsa_pkg::gdsa_rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_sums.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, actual %h", $realtime, rsp_data);
         end else begin
            want = expected_sums.pop_front();
            n_results++;
            check_field("acc_x", want.acc_x, rsp_data.acc_x);
            check_field("acc_y", want.acc_y, rsp_data.acc_y);
            check_field("acc_z", want.acc_z, rsp_data.acc_z);
            check_field("potential", want.potential, rsp_data.potential);
         end
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 400);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= 1'b0;
      endcase
   end

   function automatic gdsa_pkg::gdsa_req_type mk(logic op, logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z, logic [31:0] m,
                                                 id_type id, logic lst);
      gdsa_pkg::gdsa_req_type it;
      it.opcode = op;
      it.pos_x = x;
      it.pos_y = y;
      it.pos_z = z;
      it.mass = m;
      it.particle_id = id;
      it.last = lst;
      return it;
   endfunction

   function automatic logic [31:0] near(logic [31:0] c);
      return c + ($signed($urandom) >>> $urandom_range(4, 30));
   endfunction

   // usually one target with a short list of sources, mostly well formed
   task automatic push_group();
      logic [31:0] tx, ty, tz, m;
      id_type tid;
      int n_src, kind;
      tx = ($urandom_range(0, 3) == 0) ? $urandom : near(0);
      ty = ($urandom_range(0, 3) == 0) ? $urandom : near(0);
      tz = ($urandom_range(0, 3) == 0) ? $urandom : near(0);
      tid = id_type'($urandom);
      if ($urandom_range(0, 9) != 0)
         pending_items.push_back(mk(gdsa_pkg::OPC_TARGET, tx, ty, tz, $urandom, tid,
                                    1'($urandom_range(0, 1))));
      n_src = $urandom_range(1, 4);
      for (int i = 0; i < n_src; i++) begin
         kind = $urandom_range(0, 19);
         m = ($urandom_range(0, 9) == 0) ? 32'hffff_ffff : $urandom;
         if (kind < 12)
            pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, near(tx), near(ty), near(tz),
                                       m, id_type'($urandom), i == n_src - 1));
         else if (kind < 15)
            pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, $urandom, $urandom, $urandom,
                                       m, id_type'($urandom),
                                       1'($urandom_range(0, 1))));
         else if (kind < 17)     // self source
            pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, $urandom, $urandom, $urandom,
                                       m, tid, i == n_src - 1));
         else                    // zero separation
            pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, tx, ty, tz, m, tid + 1'b1,
                                       i == n_src - 1));
      end
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_sums.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(logic [31:0] v);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= v;
      scale_m = v;
      n_scales++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [31:0] scales[5];
      scales = '{32'h0100_0000, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 32'h0};
      scales[4] = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: sources before any target use the origin and id 0
      pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, 32'h0100_0000, 0, 0, 32'h8000_0000,
                                 id_type'(5), 1'b1));
      pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, 0, 0, 0, 32'hffff_ffff,
                                 id_type'(7), 1'b1));
      pending_items.push_back(mk(gdsa_pkg::OPC_TARGET, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h7fff_ffff, 0, '1, 1'b1));
      pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'hffff_ffff, id_type'(0), 1'b0));
      pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, 32'h7fff_fffe, 32'h7fff_ffff,
                                 32'h7fff_ffff, 32'hffff_ffff, id_type'(1), 1'b1));
      pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, 0, 0, 0, 32'hffff_ffff, '1, 1'b1));
      pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h7fff_ffff, 32'h1234_5678, id_type'(3), 1'b1));
      // accumulation carries on after a result
      pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, 0, 32'h8000_0000, 32'h7fff_ffff, 0,
                                 id_type'(4), 1'b1));
      pending_items.push_back(mk(gdsa_pkg::OPC_TARGET, 32'h8000_0000, 0, 32'h7fff_ffff, 0,
                                 id_type'(0), 1'b0));
      pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, 32'h8000_0001, 0, 32'h7fff_ffff,
                                 32'hffff_ffff, id_type'(9), 1'b0));
      pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, 32'h8000_0000, 1, 32'h7fff_fffe,
                                 32'hffff_ffff, id_type'(9), 1'b1));
      pending_items.push_back(mk(gdsa_pkg::OPC_TARGET, 0, 0, 0, 0, id_type'(0), 1'b0));
      pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, 32'h0000_0001, 0, 0, 32'h0000_0001,
                                 id_type'(1), 1'b1));
      for (int p = 0; p < 5; p++) begin
         if (p != 0) write_scale(scales[p]);
         @(negedge clock);
         for (int i = 0; i < 32; i++) push_group();
         if (p == 0) begin
            // directed again at the largest scale: saturation
            write_scale(32'hffff_ffff);
            @(negedge clock);
            for (int i = 0; i < 4; i++)
               pending_items.push_back(mk(gdsa_pkg::OPC_SOURCE, 32'h0000_0001, 0, 0,
                                          32'hffff_ffff, id_type'(2), i == 3));
            write_scale(32'h0100_0000);
         end
      end
      wait_idle();
      $display("covered %0d target loads, %0d sources (%0d skipped), %0d results, %0d scales",
               n_targets, n_sources, n_skipped, n_results, n_scales);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
